// ----- src/tun_pkg.sv -----
package tun_pkg;

    // Field and datapath widths.
    localparam int COORD_W = 24;
    localparam int EDGE_W  = 25;
    localparam int PROD_W  = 50;
    localparam int CROSS_W = 51;
    localparam int MAG_W   = 50;
    localparam int BITS_W  = 6;
    localparam int SH_W    = 5;
    localparam int KEEP_W  = 31;
    localparam int SQ_W    = 62;
    localparam int SUM_W   = 64;
    localparam int QUO_W   = 33;
    localparam int ROOT_W  = 17;
    localparam int CSQ_W   = 35;
    localparam int OUT_W   = 16;

    localparam logic [OUT_W-1:0] OUT_MAX = 16'h7FFF;

    // Control that travels with every beat through the pipeline.
    typedef struct packed {
        logic       valid;
        logic       deg;
        logic [2:0] neg;
    } t_ctl;

endpackage

// ----- src/tun_if.sv -----
interface tun_in_if;
    import tun_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface tun_out_if;
    import tun_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ----- src/tun_front.sv -----
module tun_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [tun_pkg::COORD_W-1:0] i_pt [9],
    output tun_pkg::t_ctl                      o_ctl,
    output logic [tun_pkg::SQ_W-1:0]           o_sq [3],
    output logic [tun_pkg::SUM_W-1:0]          o_sum
);
    import tun_pkg::*;

    localparam int STG_N = 8;

    t_ctl                      r_ctl [STG_N];
    t_ctl                      n_ctl [STG_N];
    logic signed [EDGE_W-1:0]  r_ue [3];
    logic signed [EDGE_W-1:0]  r_ve [3];
    logic signed [EDGE_W-1:0]  n_ue [3];
    logic signed [EDGE_W-1:0]  n_ve [3];
    logic signed [PROD_W-1:0]  r_p [6];
    logic signed [PROD_W-1:0]  n_p [6];
    logic signed [CROSS_W-1:0] r_c [3];
    logic signed [CROSS_W-1:0] n_c [3];
    logic [MAG_W-1:0]          r_mag4 [3];
    logic [MAG_W-1:0]          n_mag4 [3];
    logic [MAG_W-1:0]          r_mag5 [3];
    logic [MAG_W-1:0]          r_any;
    logic [MAG_W-1:0]          n_any;
    logic [BITS_W-1:0]         w_bits;
    logic [SH_W-1:0]           r_sh;
    logic [SH_W-1:0]           n_sh;
    logic [KEEP_W-1:0]         r_r [3];
    logic [KEEP_W-1:0]         n_r [3];
    logic [SQ_W-1:0]           r_sq7 [3];
    logic [SQ_W-1:0]           n_sq7 [3];
    logic [SQ_W-1:0]           r_sq8 [3];
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          n_sum;

    // Edges, products, cross components, magnitudes, scaling, squares and sum.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_ue[l] = EDGE_W'(i_pt[3+l]) - EDGE_W'(i_pt[l]);
            n_ve[l] = EDGE_W'(i_pt[6+l]) - EDGE_W'(i_pt[l]);
        end
        n_p[0] = r_ue[1] * r_ve[2];
        n_p[1] = r_ue[2] * r_ve[1];
        n_p[2] = r_ue[2] * r_ve[0];
        n_p[3] = r_ue[0] * r_ve[2];
        n_p[4] = r_ue[0] * r_ve[1];
        n_p[5] = r_ue[1] * r_ve[0];
        n_any = '0;
        for (int l = 0; l < 3; l++) begin
            n_c[l] = CROSS_W'(r_p[2*l]) - CROSS_W'(r_p[2*l+1]);
            n_mag4[l] = r_c[l][CROSS_W-1] ? MAG_W'(-r_c[l]) : MAG_W'(r_c[l]);
            n_any = n_any | n_mag4[l];
        end
        // Bit length of the largest magnitude; the OR of all three has the same length.
        w_bits = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r_any[i]) begin
                w_bits = BITS_W'(i + 1);
            end
        end
        n_sh = (w_bits > BITS_W'(KEEP_W)) ? SH_W'(w_bits - BITS_W'(KEEP_W)) : '0;
        for (int l = 0; l < 3; l++) begin
            n_r[l] = KEEP_W'(r_mag5[l] >> r_sh);
            n_sq7[l] = SQ_W'(r_r[l]) * SQ_W'(r_r[l]);
        end
        n_sum = SUM_W'(r_sq7[0]) + SUM_W'(r_sq7[1]) + SUM_W'(r_sq7[2]);
    end

    // Control chain; signs join at the magnitude stage, the zero flag one stage later.
    always_comb begin
        n_ctl[0] = '{valid: i_valid, deg: 1'b0, neg: 3'b000};
        for (int s = 1; s < STG_N; s++) begin
            n_ctl[s] = r_ctl[s-1];
        end
        n_ctl[3].neg = {r_c[2][CROSS_W-1], r_c[1][CROSS_W-1], r_c[0][CROSS_W-1]};
        n_ctl[4].deg = (r_any == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STG_N; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ue   <= n_ue;
            r_ve   <= n_ve;
            r_p    <= n_p;
            r_c    <= n_c;
            r_mag4 <= n_mag4;
            r_any  <= n_any;
            r_mag5 <= r_mag4;
            r_sh   <= n_sh;
            r_r    <= n_r;
            r_sq7  <= n_sq7;
            r_sq8  <= r_sq7;
            r_sum  <= n_sum;
        end
    end

    assign o_ctl = r_ctl[STG_N-1];
    assign o_sq  = r_sq8;
    assign o_sum = r_sum;

endmodule

// ----- src/tun_div.sv -----
module tun_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  tun_pkg::t_ctl             i_ctl,
    input  logic [tun_pkg::SQ_W-1:0]  i_sq [3],
    input  logic [tun_pkg::SUM_W-1:0] i_sum,
    output tun_pkg::t_ctl             o_ctl,
    output logic [tun_pkg::QUO_W-1:0] o_quo [3]
);
    import tun_pkg::*;

    // One quotient bit per stage of floor(sq * 2^32 / sum), which is at most 2^32.
    t_ctl             r_ctl [QUO_W];
    logic [SUM_W-1:0] r_sum [QUO_W];
    logic [SUM_W-1:0] r_rem [QUO_W][3];
    logic [QUO_W-1:0] r_quo [QUO_W][3];
    logic [SUM_W-1:0] n_rem [QUO_W][3];
    logic [QUO_W-1:0] n_quo [QUO_W][3];

    always_comb begin
        logic [SUM_W-1:0] v_rem;
        logic [SUM_W-1:0] v_sum;
        logic [QUO_W-1:0] v_quo;
        logic             v_bit;
        logic [SUM_W:0]   v_try;
        for (int j = 0; j < QUO_W; j++) begin
            for (int l = 0; l < 3; l++) begin
                if (j == 0) begin
                    // The upper dividend bits are sq / 2, already below the divisor.
                    v_rem = SUM_W'(i_sq[l][SQ_W-1:1]);
                    v_sum = i_sum;
                    v_quo = '0;
                    v_bit = i_sq[l][0];
                end else begin
                    v_rem = r_rem[j-1][l];
                    v_sum = r_sum[j-1];
                    v_quo = r_quo[j-1][l];
                    v_bit = 1'b0;
                end
                v_try = {v_rem, v_bit};
                if (v_try >= {1'b0, v_sum}) begin
                    n_rem[j][l] = SUM_W'(v_try - {1'b0, v_sum});
                    n_quo[j][l] = {v_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[j][l] = v_try[SUM_W-1:0];
                    n_quo[j][l] = {v_quo[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QUO_W; j++) begin
                r_ctl[j] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int j = 1; j < QUO_W; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum[0] <= i_sum;
            for (int j = 1; j < QUO_W; j++) begin
                r_sum[j] <= r_sum[j-1];
            end
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_ctl = r_ctl[QUO_W-1];
    assign o_quo = r_quo[QUO_W-1];

endmodule

// ----- src/tun_sqrt.sv -----
module tun_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  tun_pkg::t_ctl              i_ctl,
    input  logic [tun_pkg::QUO_W-1:0]  i_quo [3],
    output tun_pkg::t_ctl              o_ctl,
    output logic [tun_pkg::ROOT_W-1:0] o_root [3]
);
    import tun_pkg::*;

    // One root bit per stage, MSB first; the root square is kept incrementally.
    t_ctl              r_ctl [ROOT_W];
    logic [QUO_W-1:0]  r_q [ROOT_W][3];
    logic [ROOT_W-1:0] r_root [ROOT_W][3];
    logic [CSQ_W-1:0]  r_rsq [ROOT_W][3];
    logic [ROOT_W-1:0] n_root [ROOT_W][3];
    logic [CSQ_W-1:0]  n_rsq [ROOT_W][3];
    logic [QUO_W-1:0]  n_q [ROOT_W][3];

    always_comb begin
        logic [QUO_W-1:0]  v_q;
        logic [ROOT_W-1:0] v_root;
        logic [CSQ_W-1:0]  v_rsq;
        logic [CSQ_W-1:0]  v_cand;
        for (int j = 0; j < ROOT_W; j++) begin
            for (int l = 0; l < 3; l++) begin
                if (j == 0) begin
                    v_q    = i_quo[l];
                    v_root = '0;
                    v_rsq  = '0;
                end else begin
                    v_q    = r_q[j-1][l];
                    v_root = r_root[j-1][l];
                    v_rsq  = r_rsq[j-1][l];
                end
                // (t + 2^b)^2 = t^2 + t * 2^(b+1) + 2^(2b)
                v_cand = v_rsq + (CSQ_W'(v_root) << (ROOT_W - j))
                       + (CSQ_W'(1) << (2 * (ROOT_W - 1 - j)));
                n_q[j][l] = v_q;
                if (v_cand <= CSQ_W'(v_q)) begin
                    n_root[j][l] = v_root | (ROOT_W'(1) << (ROOT_W - 1 - j));
                    n_rsq[j][l]  = v_cand;
                end else begin
                    n_root[j][l] = v_root;
                    n_rsq[j][l]  = v_rsq;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ROOT_W; j++) begin
                r_ctl[j] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int j = 1; j < ROOT_W; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= n_q;
            r_root <= n_root;
            r_rsq  <= n_rsq;
        end
    end

    assign o_ctl  = r_ctl[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];

endmodule

// ----- src/triangle_unit_normal_core.sv -----
// Throughput: one triangle per cycle; the 33-stage divider and 17-stage root pipelines
// each retire one beat per cycle, and a stalled output freezes every stage in place.
// Reset (synchronous, active low) clears all valid bits; input ready is low during reset.
module triangle_unit_normal_core (
    input logic         i_clk,
    input logic         i_rst_n,
    tun_in_if.sink      i_tri,
    tun_out_if.source   o_nrm
);
    import tun_pkg::*;

    logic                      w_en;
    logic                      w_in_valid;
    logic signed [COORD_W-1:0] w_pt [9];
    t_ctl                      w_f_ctl;
    logic [SQ_W-1:0]           w_sq [3];
    logic [SUM_W-1:0]          w_sum;
    t_ctl                      w_d_ctl;
    logic [QUO_W-1:0]          w_quo [3];
    t_ctl                      w_s_ctl;
    logic [ROOT_W-1:0]         w_root [3];
    logic [OUT_W-1:0]          n_nrm [3];
    logic [OUT_W-1:0]          r_nrm [3];
    logic                      r_out_valid;
    logic                      r_deg;

    // The whole pipeline advances unless a finished beat waits at the output.
    assign w_en        = !r_out_valid || o_nrm.ready;
    assign i_tri.ready = i_rst_n && w_en;
    assign w_in_valid  = i_tri.valid && i_tri.ready;

    assign w_pt[0] = i_tri.a_x;
    assign w_pt[1] = i_tri.a_y;
    assign w_pt[2] = i_tri.a_z;
    assign w_pt[3] = i_tri.b_x;
    assign w_pt[4] = i_tri.b_y;
    assign w_pt[5] = i_tri.b_z;
    assign w_pt[6] = i_tri.c_x;
    assign w_pt[7] = i_tri.c_y;
    assign w_pt[8] = i_tri.c_z;

    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_valid),
        .i_pt    (w_pt),
        .o_ctl   (w_f_ctl),
        .o_sq    (w_sq),
        .o_sum   (w_sum)
    );

    tun_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_f_ctl),
        .i_sq    (w_sq),
        .i_sum   (w_sum),
        .o_ctl   (w_d_ctl),
        .o_quo   (w_quo)
    );

    tun_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_d_ctl),
        .i_quo   (w_quo),
        .o_ctl   (w_s_ctl),
        .o_root  (w_root)
    );

    // The output magnitude is (root + 1) / 2, saturated, then signed; a degenerate beat gives zero.
    always_comb begin
        logic [ROOT_W:0]   v_inc;
        logic [ROOT_W-1:0] v_k;
        logic [OUT_W-1:0]  v_mag;
        for (int l = 0; l < 3; l++) begin
            v_inc = {1'b0, w_root[l]} + (ROOT_W+1)'(1);
            v_k   = v_inc[ROOT_W:1];
            v_mag = (v_k > {1'b0, OUT_MAX}) ? OUT_MAX : v_k[OUT_W-1:0];
            if (w_s_ctl.deg) begin
                n_nrm[l] = '0;
            end else if (w_s_ctl.neg[l]) begin
                n_nrm[l] = -v_mag;
            end else begin
                n_nrm[l] = v_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_s_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nrm <= n_nrm;
            r_deg <= w_s_ctl.deg;
        end
    end

    assign o_nrm.valid      = r_out_valid;
    assign o_nrm.normal_x   = r_nrm[0];
    assign o_nrm.normal_y   = r_nrm[1];
    assign o_nrm.normal_z   = r_nrm[2];
    assign o_nrm.degenerate = r_deg;

endmodule

// ----- src/tun_chk.sv -----
module tun_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tun_pkg::OUT_W-1:0]  i_nx,
    input logic [tun_pkg::OUT_W-1:0]  i_ny,
    input logic [tun_pkg::OUT_W-1:0]  i_nz,
    input logic                       i_deg
);
    import tun_pkg::*;

    // A result beat waiting for the sink stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    // Reset empties the pipeline.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // A degenerate triangle gives a zero normal.
    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_deg |-> i_nx == '0 && i_ny == '0 && i_nz == '0)
        else $error("degenerate beat with nonzero normal");

    // A proper triangle has at least one large component, so never an all-zero normal.
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_deg |-> i_nx != '0 || i_ny != '0 || i_nz != '0)
        else $error("zero normal without degenerate flag");

endmodule

bind triangle_unit_normal_core tun_chk u_tun_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_nrm.valid),
    .i_out_ready (o_nrm.ready),
    .i_nx        (o_nrm.normal_x),
    .i_ny        (o_nrm.normal_y),
    .i_nz        (o_nrm.normal_z),
    .i_deg       (o_nrm.degenerate)
);
